// File: design/mssc_pkg.sv
// Shared types and constants for the multiplexed seven-segment scanner.
// Used by mssc_ctrl, mssc_datapath and the top level.
`timescale 1ns / 1ps

package mssc_pkg;

  // command codes on in_command
  localparam logic [1:0] CMD_LOAD_UPPER = 2'd0;  // slots 0-3
  localparam logic [1:0] CMD_LOAD_LOWER = 2'd1;  // slots 4-7
  localparam logic [1:0] CMD_SCAN       = 2'd2;
  localparam logic [1:0] CMD_NOP        = 2'd3;

  localparam int VALUE_W = 32;
  localparam int BCD_W   = 16;
  localparam int FRAME_W = 16;
  localparam int CNT_W   = 5;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_W - 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(FRAME_W - 1);

  // active-low digit select byte per position, board wiring order
  localparam logic [7:0] SEL_TABLE [8] = '{
    8'hfb, 8'hfd, 8'hfe, 8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f
  };

  // segment byte per slot code: digits, dash, point, blank
  localparam logic [7:0] SEG_TABLE [16] = '{
    8'h28, 8'heb, 8'h32, 8'ha2, 8'he1, 8'ha4, 8'h24, 8'hea,
    8'h20, 8'ha0, 8'hf7, 8'hdf, 8'hff, 8'hff, 8'hff, 8'hff
  };

  localparam logic [7:0] SEL_NONE = 8'hff;

  // controller to datapath commands
  typedef struct packed {
    logic load_init;
    logic load_group;
    logic conv_shift;
    logic conv_write;
    logic scan_init;
    logic scan_shift;
    logic pos_advance;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic conv_last;
    logic scan_last;
  } sts_t;

endpackage

// File: design/multiplexed_seven_segment_scanner.sv
// Top level of the multiplexed seven-segment scanner.
// Instantiates mssc_ctrl and mssc_datapath; types from mssc_pkg.
//
// Usage: a word is accepted at a clock edge with start high and busy low.
// in_command selects: load upper slots 0-3, load lower slots 4-7, scan tick,
// or nothing. A load splits in_value into its four low decimal digits with
// a shift-add-3 converter, one input bit a cycle; it gives no result and
// keeps busy high through the conversion and the slot write that ends it.
// A scan tick emits 16 serial bits, one a cycle, with out_valid high for
// exactly one cycle each: the active-low select byte then the segment byte,
// each lsb first; out_latch_after marks the sixteenth. The frame is loaded
// at acceptance and each bit then passes through the output register; busy
// stays high while the frame shifter runs, so no new word is taken until
// the last bit has been shifted out.
// The receiver cannot stall: each output bit stands for one cycle only.
// Reset (rst_n low, synchronous) sets slot k to k+1 and the scan position
// to the first digit, and drops any word in progress.
`timescale 1ns / 1ps

module multiplexed_seven_segment_scanner
  import mssc_pkg::*;
#(
  parameter int NUM_DIGITS = 8
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  output logic               out_serial_bit,
  output logic               out_latch_after,
  output logic [2:0]         out_shown_position
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  mssc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .busy       (busy),
    .cmd        (cmd)
  );

  // storage, conversion and serializer
  mssc_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_value           (in_value),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_serial_bit     (out_serial_bit),
    .out_latch_after    (out_latch_after),
    .out_shown_position (out_shown_position)
  );

endmodule

// File: design/mssc_ctrl.sv
// Controller state machine of the seven-segment scanner.
// Depends on mssc_pkg for command codes and the cmd_t / sts_t structs.
`timescale 1ns / 1ps

module mssc_ctrl
  import mssc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  sts_t       sts,
  output logic       busy,
  output cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CONV  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_LOAD_UPPER, CMD_LOAD_LOWER: begin
              cmd.load_init  = 1'b1;
              cmd.load_group = (in_command == CMD_LOAD_LOWER);
              state_nxt      = S_CONV;
            end
            CMD_SCAN: begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
            CMD_NOP: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        cmd.conv_shift = 1'b1;
        if (sts.conv_last) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.conv_write = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_shift = 1'b1;
        if (sts.scan_last) begin
          cmd.pos_advance = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/mssc_datapath.sv
// Datapath of the seven-segment scanner: digit slots, shift-add-3 decimal
// converter, scan frame shifter and output word registers. Uses mssc_pkg.
`timescale 1ns / 1ps

module mssc_datapath
  import mssc_pkg::*;
#(
  parameter int NUM_DIGITS = 8
)(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [VALUE_W-1:0] in_value,
  output sts_t               sts,
  output logic               out_valid,
  output logic               out_serial_bit,
  output logic               out_latch_after,
  output logic [2:0]         out_shown_position
);

  localparam int POS_W = $clog2(NUM_DIGITS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

  logic [3:0]         slots_r [NUM_DIGITS];
  logic [POS_W-1:0]   pos_r;
  logic [2:0]         shown_r;
  logic               group_r;
  logic [VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt_r;
  logic [FRAME_W-1:0] frame_r;
  logic               out_valid_r;
  logic               out_bit_r;
  logic               out_latch_r;
  logic [4:0]         pos_ext;
  logic [7:0]         sel_byte;
  logic [7:0]         seg_byte;

  assign sts.conv_last = (cnt_r == CONV_LAST);
  assign sts.scan_last = (cnt_r == SCAN_LAST);

  // add 3 to every decimal digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < BCD_W / 4; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  // select and segment bytes for the current position
  assign pos_ext  = 5'(pos_r);
  assign sel_byte = (pos_ext < 5'd8) ? SEL_TABLE[pos_ext[2:0]] : SEL_NONE;
  assign seg_byte = SEG_TABLE[slots_r[pos_r]];

  // converter, counter and frame shifter
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      bin_r   <= in_value;
      bcd_r   <= '0;
      cnt_r   <= '0;
      group_r <= cmd.load_group;
    end else if (cmd.conv_shift) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_r <= {bin_r[VALUE_W-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.scan_init) begin
      frame_r <= {seg_byte, sel_byte};
      shown_r <= pos_ext[2:0];
      cnt_r   <= '0;
    end else if (cmd.scan_shift) begin
      frame_r <= {1'b0, frame_r[FRAME_W-1:1]};
      cnt_r   <= cnt_r + CNT_W'(1);
    end
  end

  // digit slots and scan position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        slots_r[k] <= 4'(k + 1);
      end
      pos_r <= '0;
    end else begin
      if (cmd.conv_write) begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
          if (k < 8 && (k / 4 == 1) == group_r) begin
            slots_r[k] <= bcd_r[4*(3 - (k % 4)) +: 4];
          end
        end
      end
      if (cmd.pos_advance) begin
        pos_r <= (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
      end
    end
  end

  // output word registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.scan_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_shift) begin
      out_bit_r   <= frame_r[0];
      out_latch_r <= sts.scan_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_serial_bit     = out_bit_r;
  assign out_latch_after    = out_latch_r;
  assign out_shown_position = shown_r;

endmodule
